[hdl/tip_pkg.sv]
// Shared widths, register indexes, pipeline side-data types and helpers for the torus projector.
package tip_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_HALF_WIDTH = 2'd1;

    localparam int COORD_W = 32;
    localparam int REG_W = 31;
    localparam int ROOT_W = 32;   // both square roots produce 32 result bits
    localparam int DVD_W = 66;    // dividend width in both dividers
    localparam int LEN_W = 33;    // distance to backbone, may carry one extra bit
    localparam int QA_W = 33;     // quotient bits, radial offset and z scaling
    localparam int QB_W = 34;     // quotient bits, x and y scaling

    // carried through the radial square root
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } sa_t;

    // carried through the tube-distance square root
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        rxy;
        logic [31:0]        adr;
        logic               big;
        logic               in_tube;
        logic               degen;
        logic               dr_neg;
    } sb_t;

    // carried through the first divider
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               z_neg;
        logic [31:0]        rxy;
        logic               degen;
        logic               in_tube;
        logic               dr_neg;
    } sc_t;

    // carried through the second divider
    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic signed [33:0] pz;
        logic               degen;
        logic               in_tube;
    } sd_t;

    typedef struct packed {
        logic               in_tube;
        logic               degen;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } out_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -36'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

[hdl/tip_sqrt_cell.sv]
// One result bit of a pipelined restoring integer square root.
module tip_sqrt_cell #(
    parameter int ROOT_W = tip_pkg::ROOT_W,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] in_rad,
    input  logic [ROOT_W+1:0]   in_rem,
    input  logic [ROOT_W-1:0]   in_root,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [2*ROOT_W-1:0] out_rad,
    output logic [ROOT_W+1:0]   out_rem,
    output logic [ROOT_W-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    logic                valid_reg;
    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [ROOT_W+1:0]   rem_t;
    logic [ROOT_W+1:0]   trial;
    logic                ge;

    always_comb
    begin
        // bring down the next two radicand bits, try root*4+1
        rem_t     = {in_rem[ROOT_W-1:0], in_rad[2*ROOT_W-1 -: 2]};
        trial     = {in_root, 2'b01};
        ge        = rem_t >= trial;
        rem_next  = ge ? (rem_t - trial) : rem_t;
        root_next = {in_root[ROOT_W-2:0], ge};
        rad_next  = {in_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

[hdl/tip_div_cell.sv]
// One quotient bit of a two-lane pipelined restoring divider with a shared divisor.
module tip_div_cell #(
    parameter int DVD_W  = tip_pkg::DVD_W,
    parameter int DIV_W  = 32,
    parameter int QUO_W  = 34,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  in_rem_a,
    input  logic [DVD_W-1:0]  in_rem_b,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [QUO_W-1:0]  in_quo_a,
    input  logic [QUO_W-1:0]  in_quo_b,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DVD_W-1:0]  out_rem_a,
    output logic [DVD_W-1:0]  out_rem_b,
    output logic [DIV_W-1:0]  out_div,
    output logic [QUO_W-1:0]  out_quo_a,
    output logic [QUO_W-1:0]  out_quo_b,
    output logic [SIDE_W-1:0] out_side
);

    localparam int HI_W = DVD_W - SHIFT;

    logic              valid_reg;
    logic [DVD_W-1:0]  rem_a_reg, rem_a_next;
    logic [DVD_W-1:0]  rem_b_reg, rem_b_next;
    logic [DIV_W-1:0]  div_reg;
    logic [QUO_W-1:0]  quo_a_reg, quo_a_next;
    logic [QUO_W-1:0]  quo_b_reg, quo_b_next;
    logic [SIDE_W-1:0] side_reg;
    logic [HI_W-1:0]   div_hi;
    logic [DVD_W-1:0]  sub;
    logic              ge_a;
    logic              ge_b;

    always_comb
    begin
        // rem >= div<<SHIFT compared on the upper bits only
        div_hi = {{(HI_W-DIV_W){1'b0}}, in_div};
        sub    = {{(DVD_W-DIV_W){1'b0}}, in_div} << SHIFT;
        ge_a   = in_rem_a[DVD_W-1:SHIFT] >= div_hi;
        ge_b   = in_rem_b[DVD_W-1:SHIFT] >= div_hi;
        rem_a_next = ge_a ? (in_rem_a - sub) : in_rem_a;
        rem_b_next = ge_b ? (in_rem_b - sub) : in_rem_b;
        quo_a_next = in_quo_a;
        quo_b_next = in_quo_b;
        quo_a_next[SHIFT] = ge_a;
        quo_b_next[SHIFT] = ge_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            div_reg   <= in_div;
            quo_a_reg <= quo_a_next;
            quo_b_reg <= quo_b_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_a = rem_a_reg;
    assign out_rem_b = rem_b_reg;
    assign out_div   = div_reg;
    assign out_quo_a = quo_a_reg;
    assign out_quo_b = quo_b_reg;
    assign out_side  = side_reg;

endmodule

[hdl/torus_inside_and_project_core.sv]
// Top level of the torus inside test and surface projector: a chain of sqrt and divide cells.
//
// One point enters per cycle except while the chain holds; its result passes through
// a chain of cells: two 32-cell square roots (radial distance, then distance to
// the backbone), a 33-cell divider for the radial offset and z scaling, a 34-cell divider
// for x and y scaling, and seven register stages for squares, offsets, products and the
// output. The output register has a one-beat skid behind it, so the input keeps flowing
// while a result waits; the whole chain holds only when both are full. in_ready is
// registered. Configuration writes are always taken (cfg_ready is high); the registers are
// read at several points along the chain, so write them only while no item is in flight.
// Index 0 is ring_radius, index 1 tube_half_width, others are ignored.
module torus_inside_and_project_core #(
    parameter int FRAC_BITS = tip_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_inside,
    output logic                           degenerate,
    output logic signed [31:0]             proj_x,
    output logic signed [31:0]             proj_y,
    output logic signed [31:0]             proj_z,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tip_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    import tip_pkg::*;

    localparam int SA_W = $bits(sa_t);
    localparam int SB_W = $bits(sb_t);
    localparam int SC_W = $bits(sc_t);
    localparam int SD_W = $bits(sd_t);

    // ---------------- configuration ----------------
    logic [REG_W-1:0] ring_reg;
    logic [REG_W-1:0] tube_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= REG_W'(64'd2 << FRAC_BITS);
            tube_reg <= REG_W'(64'd1 << FRAC_BITS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RING_RADIUS:     ring_reg <= cfg_data[REG_W-1:0];
                CFG_TUBE_HALF_WIDTH: tube_reg <= cfg_data[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic en;
    logic skid_v_reg;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    // ---------------- stage 1: squares of x and y ----------------
    logic        p1_v_reg;
    logic [63:0] p1_sqx_reg;
    logic [63:0] p1_sqy_reg;
    sa_t         p1_side_reg;
    logic [31:0] in_ax;
    logic [31:0] in_ay;

    assign in_ax = mag32(pos_x);
    assign in_ay = mag32(pos_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_v_reg <= 1'b0;
        else if (en)
            p1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_sqx_reg    <= in_ax * in_ax;
            p1_sqy_reg    <= in_ay * in_ay;
            p1_side_reg.x <= pos_x;
            p1_side_reg.y <= pos_y;
            p1_side_reg.z <= pos_z;
        end
    end

    // ---------------- square root chain A: rxy ----------------
    logic [ROOT_W:0]     a_v;
    logic [2*ROOT_W-1:0] a_rad  [0:ROOT_W];
    logic [ROOT_W+1:0]   a_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]   a_root [0:ROOT_W];
    logic [SA_W-1:0]     a_side [0:ROOT_W];

    assign a_v[0]    = p1_v_reg;
    assign a_rad[0]  = p1_sqx_reg + p1_sqy_reg;
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_side[0] = p1_side_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt_a
        tip_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .SIDE_W (SA_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (a_v[k]),
            .in_rad    (a_rad[k]),
            .in_rem    (a_rem[k]),
            .in_root   (a_root[k]),
            .in_side   (a_side[k]),
            .out_valid (a_v[k+1]),
            .out_rad   (a_rad[k+1]),
            .out_rem   (a_rem[k+1]),
            .out_root  (a_root[k+1]),
            .out_side  (a_side[k+1])
        );
    end

    // ---------------- stage 2: radial offset ----------------
    sa_t         sa_o;
    logic [31:0] rxy_a;
    logic [33:0] dr34;
    logic [33:0] ndr34;
    logic        dr_neg;
    logic [31:0] adr;
    logic [31:0] az_a;
    logic        big;
    logic        over;
    logic        degen_a;

    always_comb
    begin
        sa_o    = sa_t'(a_side[ROOT_W]);
        rxy_a   = a_root[ROOT_W];
        dr34    = {2'b00, rxy_a} - {3'b000, ring_reg};
        ndr34   = 34'd0 - dr34;
        dr_neg  = dr34[33];
        adr     = dr_neg ? ndr34[31:0] : dr34[31:0];
        az_a    = mag32(sa_o.z);
        // halve both legs when either reaches 2^31 so the sum of squares fits
        big     = adr[31] | az_a[31];
        over    = (adr > {1'b0, tube_reg}) || (az_a > {1'b0, tube_reg});
        degen_a = (rxy_a == '0) || ((dr34 == '0) && (sa_o.z == '0));
    end

    logic        p2_v_reg;
    logic [30:0] p2_la_reg;
    logic [30:0] p2_lb_reg;
    logic        p2_over_reg;
    sb_t         p2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_v_reg <= 1'b0;
        else if (en)
            p2_v_reg <= a_v[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_la_reg           <= big ? adr[31:1] : adr[30:0];
            p2_lb_reg           <= big ? az_a[31:1] : az_a[30:0];
            p2_over_reg         <= over;
            p2_side_reg.x       <= sa_o.x;
            p2_side_reg.y       <= sa_o.y;
            p2_side_reg.z       <= sa_o.z;
            p2_side_reg.rxy     <= rxy_a;
            p2_side_reg.adr     <= adr;
            p2_side_reg.big     <= big;
            p2_side_reg.in_tube <= 1'b0;
            p2_side_reg.degen   <= degen_a;
            p2_side_reg.dr_neg  <= dr_neg;
        end
    end

    // ---------------- stage 3: squares of the offsets ----------------
    logic        p3_v_reg;
    logic [61:0] p3_sqa_reg;
    logic [61:0] p3_sqb_reg;
    logic [61:0] p3_sqw_reg;
    logic        p3_over_reg;
    sb_t         p3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_v_reg <= 1'b0;
        else if (en)
            p3_v_reg <= p2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_sqa_reg  <= p2_la_reg * p2_la_reg;
            p3_sqb_reg  <= p2_lb_reg * p2_lb_reg;
            p3_sqw_reg  <= tube_reg * tube_reg;
            p3_over_reg <= p2_over_reg;
            p3_side_reg <= p2_side_reg;
        end
    end

    logic [62:0] sum_l;
    sb_t         sb_in;

    always_comb
    begin
        sum_l = {1'b0, p3_sqa_reg} + {1'b0, p3_sqb_reg};
        sb_in = p3_side_reg;
        // when not over, both legs are below 2^31 and sum_l is the exact distance squared
        sb_in.in_tube = !p3_over_reg && (sum_l <= {1'b0, p3_sqw_reg});
    end

    // ---------------- square root chain B: distance to backbone ----------------
    logic [ROOT_W:0]     b_v;
    logic [2*ROOT_W-1:0] b_rad  [0:ROOT_W];
    logic [ROOT_W+1:0]   b_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]   b_root [0:ROOT_W];
    logic [SB_W-1:0]     b_side [0:ROOT_W];

    assign b_v[0]    = p3_v_reg;
    assign b_rad[0]  = {1'b0, sum_l};
    assign b_rem[0]  = '0;
    assign b_root[0] = '0;
    assign b_side[0] = sb_in;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt_b
        tip_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .SIDE_W (SB_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (b_v[k]),
            .in_rad    (b_rad[k]),
            .in_rem    (b_rem[k]),
            .in_root   (b_root[k]),
            .in_side   (b_side[k]),
            .out_valid (b_v[k+1]),
            .out_rad   (b_rad[k+1]),
            .out_rem   (b_rem[k+1]),
            .out_root  (b_root[k+1]),
            .out_side  (b_side[k+1])
        );
    end

    // ---------------- stage 4: numerators for offset and z ----------------
    sb_t              sb_o;
    logic [LEN_W-1:0] len;
    logic [31:0]      az_b;

    always_comb
    begin
        sb_o = sb_t'(b_side[ROOT_W]);
        len  = sb_o.big ? {b_root[ROOT_W], 1'b0} : {1'b0, b_root[ROOT_W]};
        az_b = mag32(sb_o.z);
    end

    logic             p4_v_reg;
    logic [62:0]      p4_pdr_reg;
    logic [62:0]      p4_pz_reg;
    logic [LEN_W-1:0] p4_len_reg;
    sc_t              p4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_v_reg <= 1'b0;
        else if (en)
            p4_v_reg <= b_v[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_pdr_reg          <= tube_reg * sb_o.adr;
            p4_pz_reg           <= tube_reg * az_b;
            p4_len_reg          <= len;
            p4_side_reg.x       <= sb_o.x;
            p4_side_reg.y       <= sb_o.y;
            p4_side_reg.z_neg   <= sb_o.z[31];
            p4_side_reg.rxy     <= sb_o.rxy;
            p4_side_reg.degen   <= sb_o.degen;
            p4_side_reg.in_tube <= sb_o.in_tube;
            p4_side_reg.dr_neg  <= sb_o.dr_neg;
        end
    end

    // ---------------- divider chain A: rounded offset and z over len ----------------
    logic [QA_W:0]      da_v;
    logic [DVD_W-1:0]   da_rem_a [0:QA_W];
    logic [DVD_W-1:0]   da_rem_b [0:QA_W];
    logic [LEN_W-1:0]   da_div   [0:QA_W];
    logic [QA_W-1:0]    da_quo_a [0:QA_W];
    logic [QA_W-1:0]    da_quo_b [0:QA_W];
    logic [SC_W-1:0]    da_side  [0:QA_W];

    assign da_v[0]     = p4_v_reg;
    assign da_rem_a[0] = {3'b000, p4_pdr_reg} + {{(DVD_W-LEN_W+1){1'b0}}, p4_len_reg[LEN_W-1:1]};
    assign da_rem_b[0] = {3'b000, p4_pz_reg} + {{(DVD_W-LEN_W+1){1'b0}}, p4_len_reg[LEN_W-1:1]};
    assign da_div[0]   = p4_len_reg;
    assign da_quo_a[0] = '0;
    assign da_quo_b[0] = '0;
    assign da_side[0]  = p4_side_reg;

    for (genvar k = 0; k < QA_W; k++)
    begin : g_div_a
        tip_div_cell #(
            .DVD_W  (DVD_W),
            .DIV_W  (LEN_W),
            .QUO_W  (QA_W),
            .SHIFT  (QA_W - 1 - k),
            .SIDE_W (SC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (da_v[k]),
            .in_rem_a  (da_rem_a[k]),
            .in_rem_b  (da_rem_b[k]),
            .in_div    (da_div[k]),
            .in_quo_a  (da_quo_a[k]),
            .in_quo_b  (da_quo_b[k]),
            .in_side   (da_side[k]),
            .out_valid (da_v[k+1]),
            .out_rem_a (da_rem_a[k+1]),
            .out_rem_b (da_rem_b[k+1]),
            .out_div   (da_div[k+1]),
            .out_quo_a (da_quo_a[k+1]),
            .out_quo_b (da_quo_b[k+1]),
            .out_side  (da_side[k+1])
        );
    end

    // ---------------- stage 5: scaled radius s ----------------
    sc_t          sc_o;
    logic [34:0]  sq1;
    logic [34:0]  s35;
    logic [34:0]  ns35;
    logic [33:0]  pzs;

    always_comb
    begin
        sc_o = sc_t'(da_side[QA_W]);
        sq1  = sc_o.dr_neg ? (35'd0 - {2'b00, da_quo_a[QA_W]}) : {2'b00, da_quo_a[QA_W]};
        s35  = {4'b0000, ring_reg} + sq1;
        ns35 = 35'd0 - s35;
        pzs  = sc_o.z_neg ? (34'd0 - {1'b0, da_quo_b[QA_W]}) : {1'b0, da_quo_b[QA_W]};
    end

    logic               p5_v_reg;
    logic [32:0]        p5_abs_s_reg;
    logic               p5_s_neg_reg;
    logic signed [31:0] p5_x_reg;
    logic signed [31:0] p5_y_reg;
    logic [31:0]        p5_rxy_reg;
    logic signed [33:0] p5_pz_reg;
    logic               p5_degen_reg;
    logic               p5_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_v_reg <= 1'b0;
        else if (en)
            p5_v_reg <= da_v[QA_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_abs_s_reg  <= s35[34] ? ns35[32:0] : s35[32:0];
            p5_s_neg_reg  <= s35[34];
            p5_x_reg      <= sc_o.x;
            p5_y_reg      <= sc_o.y;
            p5_rxy_reg    <= sc_o.rxy;
            p5_pz_reg     <= pzs;
            p5_degen_reg  <= sc_o.degen;
            p5_inside_reg <= sc_o.in_tube;
        end
    end

    // ---------------- stage 6: numerators for x and y ----------------
    logic        p6_v_reg;
    logic [64:0] p6_prodx_reg;
    logic [64:0] p6_prody_reg;
    logic [31:0] p6_rxy_reg;
    sd_t         p6_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p6_v_reg <= 1'b0;
        else if (en)
            p6_v_reg <= p5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p6_prodx_reg        <= p5_abs_s_reg * mag32(p5_x_reg);
            p6_prody_reg        <= p5_abs_s_reg * mag32(p5_y_reg);
            p6_rxy_reg          <= p5_rxy_reg;
            p6_side_reg.neg_x   <= p5_s_neg_reg != p5_x_reg[31];
            p6_side_reg.neg_y   <= p5_s_neg_reg != p5_y_reg[31];
            p6_side_reg.pz      <= p5_pz_reg;
            p6_side_reg.degen   <= p5_degen_reg;
            p6_side_reg.in_tube <= p5_inside_reg;
        end
    end

    // ---------------- divider chain B: rounded x and y over rxy ----------------
    logic [QB_W:0]    db_v;
    logic [DVD_W-1:0] db_rem_a [0:QB_W];
    logic [DVD_W-1:0] db_rem_b [0:QB_W];
    logic [31:0]      db_div   [0:QB_W];
    logic [QB_W-1:0]  db_quo_a [0:QB_W];
    logic [QB_W-1:0]  db_quo_b [0:QB_W];
    logic [SD_W-1:0]  db_side  [0:QB_W];

    assign db_v[0]     = p6_v_reg;
    assign db_rem_a[0] = {1'b0, p6_prodx_reg} + {35'd0, p6_rxy_reg[31:1]};
    assign db_rem_b[0] = {1'b0, p6_prody_reg} + {35'd0, p6_rxy_reg[31:1]};
    assign db_div[0]   = p6_rxy_reg;
    assign db_quo_a[0] = '0;
    assign db_quo_b[0] = '0;
    assign db_side[0]  = p6_side_reg;

    for (genvar k = 0; k < QB_W; k++)
    begin : g_div_b
        tip_div_cell #(
            .DVD_W  (DVD_W),
            .DIV_W  (32),
            .QUO_W  (QB_W),
            .SHIFT  (QB_W - 1 - k),
            .SIDE_W (SD_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (db_v[k]),
            .in_rem_a  (db_rem_a[k]),
            .in_rem_b  (db_rem_b[k]),
            .in_div    (db_div[k]),
            .in_quo_a  (db_quo_a[k]),
            .in_quo_b  (db_quo_b[k]),
            .in_side   (db_side[k]),
            .out_valid (db_v[k+1]),
            .out_rem_a (db_rem_a[k+1]),
            .out_rem_b (db_rem_b[k+1]),
            .out_div   (db_div[k+1]),
            .out_quo_a (db_quo_a[k+1]),
            .out_quo_b (db_quo_b[k+1]),
            .out_side  (db_side[k+1])
        );
    end

    // ---------------- result and output buffering ----------------
    sd_t         sd_o;
    logic [35:0] vx;
    logic [35:0] vy;
    out_t        res;

    always_comb
    begin
        sd_o = sd_t'(db_side[QB_W]);
        vx   = sd_o.neg_x ? (36'd0 - {2'b00, db_quo_a[QB_W]}) : {2'b00, db_quo_a[QB_W]};
        vy   = sd_o.neg_y ? (36'd0 - {2'b00, db_quo_b[QB_W]}) : {2'b00, db_quo_b[QB_W]};
        res.in_tube = sd_o.in_tube;
        res.degen   = sd_o.degen;
        if (sd_o.degen)
        begin
            res.px = '0;
            res.py = '0;
            res.pz = '0;
        end
        else
        begin
            res.px = sat32(vx);
            res.py = sat32(vy);
            res.pz = sat32({{2{sd_o.pz[33]}}, sd_o.pz});
        end
    end

    logic main_v_reg;
    out_t main_reg;
    out_t skid_reg;
    logic take;

    assign take = main_v_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (take)
                skid_v_reg <= 1'b0;
        end
        else if (db_v[QB_W])
        begin
            if (main_v_reg && !take)
                skid_v_reg <= 1'b1;
            else
                main_v_reg <= 1'b1;
        end
        else if (take)
        begin
            main_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (take)
                main_reg <= skid_reg;
        end
        else if (db_v[QB_W])
        begin
            if (main_v_reg && !take)
                skid_reg <= res;
            else
                main_reg <= res;
        end
    end

    assign out_valid  = main_v_reg;
    assign is_inside  = main_reg.in_tube;
    assign degenerate = main_reg.degen;
    assign proj_x     = main_reg.px;
    assign proj_y     = main_reg.py;
    assign proj_z     = main_reg.pz;

endmodule

[tb/sv/torus_inside_and_project_core_test.sv]
// Self-checking testbench for the torus inside test and surface projector.
module torus_inside_and_project_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tip_pkg::*;

    localparam int LATENCY = 138;
    localparam int WATCHDOG = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic               in_tube;
        logic               degen;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } proj_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic is_inside, degenerate;
    logic signed [31:0] proj_x, proj_y, proj_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    torus_inside_and_project_core i_dut (.*);

    // predictor copy of the registers
    logic [63:0] ring_r = 64'd131072;
    logic [63:0] tube_w = 64'd65536;

    proj_t expected_proj[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_recv = 0;
    int errors = 0;
    int quiet_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic signed [63:0] scale_round(input logic signed [63:0] a,
                                                       input logic signed [63:0] b,
                                                       input logic [63:0] d);
        logic [63:0] q;
        q = (abs64(a) * abs64(b) + d / 2) / d;
        return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic proj_t project_point(input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z);
        logic signed [63:0] xs, ys, zs, dr, s;
        logic [63:0] ax, ay, az, rxy, adr, len, a, b;
        proj_t r;
        xs = x;
        ys = y;
        zs = z;
        ax = abs64(xs);
        ay = abs64(ys);
        az = abs64(zs);
        rxy = root64(ax * ax + ay * ay);
        dr = $signed(rxy) - $signed(ring_r);
        adr = abs64(dr);
        r = '0;
        r.in_tube = (adr > tube_w || az > tube_w) ? 1'b0
                  : (adr * adr + az * az <= tube_w * tube_w);
        r.degen = (rxy == 0) || (dr == 0 && zs == 0);
        if (!r.degen)
        begin
            if (adr >= 64'd1 << 31 || az >= 64'd1 << 31)
            begin
                a = adr >> 1;
                b = az >> 1;
                len = 2 * root64(a * a + b * b);
            end
            else
                len = root64(adr * adr + az * az);
            s = $signed(ring_r) + scale_round($signed(tube_w), dr, len);
            r.px = clip32(scale_round(s, xs, rxy));
            r.py = clip32(scale_round(s, ys, rxy));
            r.pz = clip32(scale_round($signed(tube_w), zs, len));
        end
        return r;
    endfunction

    // valid is set with blocking writes so back-to-back beats never see two updates in one step
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_proj.push_back(project_point(x, y, z));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_proj.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_RING_RADIUS)
            ring_r = val & 32'h7fff_ffff;
        else if (idx == CFG_TUBE_HALF_WIDTH)
            tube_w = val & 32'h7fff_ffff;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(32'h0080_0000) - 32'h0040_0000;
            3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(3);
            default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    // receiver side
    always @(negedge clk)
    begin
        if (hold_recv > 0)
        begin
            hold_recv <= hold_recv - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        proj_t e;
        if (rst_n)
        begin
            quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)
                             || cfg_valid) ? 0 : quiet_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_proj.size() == 0)
                begin
                    $display("%t: unexpected result beat", $realtime);
                    errors++;
                end
                else
                begin
                    e = expected_proj.pop_front();
                    if (is_inside !== e.in_tube)
                    begin
                        $display("%t: is_inside exp %0d got %0d", $realtime, e.in_tube,
                                 is_inside);
                        errors++;
                    end
                    if (degenerate !== e.degen)
                    begin
                        $display("%t: degenerate exp %0d got %0d", $realtime, e.degen, degenerate);
                        errors++;
                    end
                    if (proj_x !== e.px)
                    begin
                        $display("%t: proj_x exp %0d got %0d", $realtime, e.px, proj_x);
                        errors++;
                    end
                    if (proj_y !== e.py)
                    begin
                        $display("%t: proj_y exp %0d got %0d", $realtime, e.py, proj_y);
                        errors++;
                    end
                    if (proj_z !== e.pz)
                    begin
                        $display("%t: proj_z exp %0d got %0d", $realtime, e.pz, proj_z);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_point(0, 0, 0);
        send_point(0, 0, 32'h0001_0000);
        send_point(32'h0002_0000, 0, 0);                 // on the backbone
        send_point(0, 32'hfffe_0000, 0);                 // on the backbone, negative y
        send_point(32'h0002_8000, 0, 32'h0000_4000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'hffff_8000);
        send_point(32'h0003_0000, 0, 0);                 // on the tube surface
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff, 0);
        send_point(1, 0, 32'h8000_0000);                 // large z offset
        send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
        send_point(32'h0002_0000, 0, 32'h0001_0000);
        send_point(32'h0002_0000, 0, 32'h0001_0001);
    endtask

    task automatic test_random(input int n);
        repeat (n)
            send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_RING_RADIUS, 32'h7fff_ffff);
        write_reg(CFG_TUBE_HALF_WIDTH, 32'h7fff_ffff);
        test_random(60);
        write_reg(CFG_RING_RADIUS, 0);
        write_reg(CFG_TUBE_HALF_WIDTH, 0);
        test_random(40);
        write_reg(CFG_RING_RADIUS, 1);
        write_reg(CFG_TUBE_HALF_WIDTH, 32'h0010_0000);   // tube wider than ring
        test_random(60);
        write_reg(CFG_SPARE_IDX, 32'h1234_5678);         // unused index, ignored
        write_reg(CFG_RING_RADIUS, 32'hffff_0000);       // top bit dropped
        write_reg(CFG_TUBE_HALF_WIDTH, 32'h0000_8000);
        test_random(60);
        write_reg(CFG_RING_RADIUS, 32'd131072);
        write_reg(CFG_TUBE_HALF_WIDTH, 32'd65536);
    endtask

    task automatic test_backpressure();
        hold_recv = 400;
        test_random(250);
        drain();
        test_random(20);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        send_idle_pct = 27;
        recv_idle_pct = 47;
        test_random(400);
        send_idle_pct = 47;
        recv_idle_pct = 27;
        test_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(246);
        test_backpressure();
        test_config_extremes();
        drain();
        if (errors == 0 && expected_proj.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
